// ===== hdl/upe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types and constants of the udp payload extractor.
// ----------------------------------------------------------------------------
package upe_pkg;

    localparam int CMP_W = 18;

    localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_TYPE_QINQ  = 16'h88A8;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IHL_MASK       = 4'h0F;
    localparam logic [5:0]  IP_HDR_MIN     = 6'd20;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_RUNT      = 3'd1,
        VERDICT_NOT_IPV4  = 3'd2,
        VERDICT_BAD_IHL   = 3'd3,
        VERDICT_NOT_UDP   = 3'd4,
        VERDICT_PORT_MISS = 3'd5,
        VERDICT_BAD_LEN   = 3'd6,
        VERDICT_TRUNC     = 3'd7
    } verdict_t;

    // one queue entry: results caused by one input item
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        stat_valid;
        verdict_t    verdict;
        logic [15:0] plen;
    } rec_t;

endpackage
`default_nettype wire

// ===== hdl/upe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upe_front
// Header parser: tracks the byte position, captures header fields, decides
// per item whether it is payload and builds the end of frame status.
// ----------------------------------------------------------------------------
module upe_front
    import upe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic [15:0] port_filter,
    output logic             push,
    output rec_t             rec
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic [15:0]      et_reg, et_next, et_upd;
    logic             tag_reg, tag_next, tag_upd;
    logic [5:0]       ihl_reg, ihl_next, ihl_upd;
    logic [7:0]       proto_reg, proto_next, proto_upd;
    logic [15:0]      dport_reg, dport_next, dport_upd;
    logic [15:0]      ulen_reg, ulen_next, ulen_upd;

    logic [CMP_W-1:0] p, ip_c, udp_c, len, ip_n, udp_n;
    logic             in_range;
    verdict_t         v_run, v_fin;
    logic             pay;

    function automatic verdict_t judge(
        input logic [CMP_W-1:0] l,
        input logic             fin,
        input logic             tag,
        input logic [15:0]      et,
        input logic [5:0]       ihl,
        input logic [7:0]       proto,
        input logic [15:0]      dport,
        input logic [15:0]      ulen,
        input logic [15:0]      pf
    );
        logic [CMP_W-1:0] ip;
        verdict_t         v;
        ip = tag ? CMP_W'(18) : CMP_W'(14);
        if (l < CMP_W'(14)) begin
            v = fin ? VERDICT_RUNT : VERDICT_OK;
        end else if (tag && l < CMP_W'(18)) begin
            v = fin ? VERDICT_RUNT : VERDICT_OK;
        end else if (et != ETH_TYPE_IPV4) begin
            v = VERDICT_NOT_IPV4;
        end else if (l < ip + CMP_W'(IP_HDR_MIN)) begin
            v = fin ? VERDICT_TRUNC : VERDICT_OK;
        end else if (ihl < IP_HDR_MIN) begin
            v = VERDICT_BAD_IHL;
        end else if (l < ip + CMP_W'(ihl) + CMP_W'(8)) begin
            v = fin ? VERDICT_TRUNC : VERDICT_OK;
        end else if (proto != IP_PROTO_UDP) begin
            v = VERDICT_NOT_UDP;
        end else if (pf != 16'd0 && dport != pf) begin
            v = VERDICT_PORT_MISS;
        end else if (ulen <= 16'd8) begin
            v = VERDICT_BAD_LEN;
        end else if (fin && (ip + CMP_W'(ihl) + CMP_W'(ulen) > l)) begin
            v = VERDICT_TRUNC;
        end else begin
            v = VERDICT_OK;
        end
        return v;
    endfunction

    assign p        = CMP_W'(pos_reg);
    assign in_range = p < CMP_W'(MAX_FRAME_BYTES);
    assign ip_c     = tag_reg ? CMP_W'(18) : CMP_W'(14);
    assign udp_c    = ip_c + CMP_W'(ihl_reg);

    // header capture for the current byte
    always_comb begin
        pos_upd   = pos_reg;
        et_upd    = et_reg;
        tag_upd   = tag_reg;
        ihl_upd   = ihl_reg;
        proto_upd = proto_reg;
        dport_upd = dport_reg;
        ulen_upd  = ulen_reg;
        if (in_range) begin
            pos_upd = pos_reg + 1'b1;
            if (p == CMP_W'(12) || p == CMP_W'(13) ||
                (tag_reg && (p == CMP_W'(16) || p == CMP_W'(17)))) begin
                et_upd = {et_reg[7:0], in_byte};
            end
            if (p == CMP_W'(13)) begin
                tag_upd = ({et_reg[7:0], in_byte} == ETH_TYPE_VLAN) ||
                          ({et_reg[7:0], in_byte} == ETH_TYPE_QINQ);
            end
            if (p == ip_c) begin
                ihl_upd = {in_byte[3:0] & IHL_MASK, 2'b00};
            end
            if (p == ip_c + CMP_W'(9)) begin
                proto_upd = in_byte;
            end
            if (p > ip_c) begin
                if (p == udp_c + CMP_W'(2) || p == udp_c + CMP_W'(3)) begin
                    dport_upd = {dport_reg[7:0], in_byte};
                end
                if (p == udp_c + CMP_W'(4) || p == udp_c + CMP_W'(5)) begin
                    ulen_upd = {ulen_reg[7:0], in_byte};
                end
            end
        end
    end

    assign len   = CMP_W'(pos_upd);
    assign ip_n  = tag_upd ? CMP_W'(18) : CMP_W'(14);
    assign udp_n = ip_n + CMP_W'(ihl_upd);

    assign v_run = judge(len, 1'b0, tag_upd, et_upd, ihl_upd, proto_upd,
                         dport_upd, ulen_upd, port_filter);
    assign v_fin = judge(len, 1'b1, tag_upd, et_upd, ihl_upd, proto_upd,
                         dport_upd, ulen_upd, port_filter);

    assign pay = in_range && (v_run == VERDICT_OK) &&
                 (len >= ip_n + CMP_W'(IP_HDR_MIN)) &&
                 (len > udp_n + CMP_W'(8)) &&
                 (p < udp_n + CMP_W'(ulen_upd));

    always_comb begin
        rec.pay_valid  = pay;
        rec.pay_byte   = in_byte;
        rec.stat_valid = in_last;
        rec.verdict    = v_fin;
        rec.plen       = (v_fin == VERDICT_OK) ? (ulen_upd - 16'd8) : 16'd0;
    end

    assign push = in_accept && (pay || in_last);

    // frame state clears after the status item
    always_comb begin
        pos_next   = pos_reg;
        et_next    = et_reg;
        tag_next   = tag_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        ulen_next  = ulen_reg;
        if (in_accept) begin
            if (in_last) begin
                pos_next   = '0;
                et_next    = '0;
                tag_next   = 1'b0;
                ihl_next   = '0;
                proto_next = '0;
                dport_next = '0;
                ulen_next  = '0;
            end else begin
                pos_next   = pos_upd;
                et_next    = et_upd;
                tag_next   = tag_upd;
                ihl_next   = ihl_upd;
                proto_next = proto_upd;
                dport_next = dport_upd;
                ulen_next  = ulen_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            et_reg    <= '0;
            tag_reg   <= 1'b0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            dport_reg <= '0;
            ulen_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            et_reg    <= et_next;
            tag_reg   <= tag_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            dport_reg <= dport_next;
            ulen_reg  <= ulen_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/upe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upe_queue
// Short first-in first-out queue of result records between parser and
// output stage.
// ----------------------------------------------------------------------------
module upe_queue
    import upe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire rec_t wr_rec,
    input  wire logic pop,
    output rec_t      rd_rec,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == CNT_W'(0));
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/upe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upe_back
// Output stage: takes records from the queue and sends their payload and
// status items through an output register.
// ----------------------------------------------------------------------------
module upe_back
    import upe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire rec_t        rd_rec,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic        valid_reg, valid_next;
    logic        stat_reg, stat_next;
    logic [7:0]  byte_reg, byte_next;
    verdict_t    verd_reg, verd_next;
    logic [15:0] plen_reg, plen_next;
    logic        pend_reg, pend_next;
    verdict_t    pverd_reg, pverd_next;
    logic [15:0] pplen_reg, pplen_next;
    logic        out_free;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        pop        = 1'b0;
        valid_next = valid_reg;
        stat_next  = stat_reg;
        byte_next  = byte_reg;
        verd_next  = verd_reg;
        plen_next  = plen_reg;
        pend_next  = pend_reg;
        pverd_next = pverd_reg;
        pplen_next = pplen_reg;
        if (out_free) begin
            if (pend_reg) begin
                valid_next = 1'b1;
                stat_next  = 1'b1;
                byte_next  = 8'd0;
                verd_next  = pverd_reg;
                plen_next  = pplen_reg;
                pend_next  = 1'b0;
            end else if (!empty) begin
                pop        = 1'b1;
                valid_next = 1'b1;
                if (rd_rec.pay_valid) begin
                    stat_next  = 1'b0;
                    byte_next  = rd_rec.pay_byte;
                    verd_next  = VERDICT_OK;
                    plen_next  = 16'd0;
                    pend_next  = rd_rec.stat_valid;
                    pverd_next = rd_rec.verdict;
                    pplen_next = rd_rec.plen;
                end else begin
                    stat_next = 1'b1;
                    byte_next = 8'd0;
                    verd_next = rd_rec.verdict;
                    plen_next = rd_rec.plen;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        stat_reg  <= stat_next;
        byte_reg  <= byte_next;
        verd_reg  <= verd_next;
        plen_reg  <= plen_next;
        pverd_reg <= pverd_next;
        pplen_reg <= pplen_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = stat_reg;
    assign m_tlast  = stat_reg;
    assign m_tdata  = {5'd0, plen_reg, verd_reg, byte_reg};

    // a held status always follows a payload item in the output register
    a_pend_after_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (valid_reg && !stat_reg))
        else $error("pending status without payload item in output");

    // payload items carry no verdict and no length
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !stat_reg) |-> (verd_reg == VERDICT_OK && plen_reg == 16'd0))
        else $error("payload item with status fields set");

    // no pop while the output register is stalled
    a_no_pop_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |-> !pop)
        else $error("queue popped while output stalled");

    // a verdict other than ok never reports a length
    a_fail_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && stat_reg && verd_reg != VERDICT_OK) |-> (plen_reg == 16'd0))
        else $error("failed frame status with nonzero length");

endmodule
`default_nettype wire

// ===== hdl/udp_payload_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_payload_extractor
// Ethernet / IPv4 / UDP receive filter passing out UDP payload bytes and
// one status item per frame.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one frame byte per item in s_tdata, s_tlast on the final byte.
//   m_ channel: payload items (m_tuser 0) with the byte in m_tdata[7:0], and
//   one status item per frame (m_tuser 1, m_tlast 1) carrying the verdict in
//   m_tdata[10:8] and the payload length in m_tdata[26:11].
//   cfg channel: cfg_data sets the UDP destination port, zero accepts all;
//   write only while the block is idle.
//   path: an accepted item reaches m_ through the queue and output register.
//   throughput: one input byte per cycle while the queue is not full; the
//   output register sends one item per cycle while m_tready is high and
//   records wait; a final byte that also carries payload gives two items,
//   the status held in a pending register and sent after the payload item.
//   stall: when m_tready is low the output register holds, the queue of
//   QUEUE_DEPTH records fills and s_tready drops once it is full.
//   reset: aresetn low clears the frame state, the queue and the port
//   register (accept every port); no item is pending after reset.
// ----------------------------------------------------------------------------
module udp_payload_extractor
    import upe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65536,
    parameter int QUEUE_DEPTH     = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // payload_byte[7:0], verdict[10:8],
                                        // payload_length[26:11], zero
    output logic             m_tlast,
    output logic             m_tuser,   // is_status[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // port_filter[15:0]
);

    logic [15:0] port_reg, port_next;
    logic        q_full, q_empty, push, pop, in_accept;
    rec_t        wr_rec, rd_rec;

    assign cfg_ready = 1'b1;
    assign port_next = (cfg_valid && cfg_ready) ? cfg_data : port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_reg <= 16'd0;
        end else begin
            port_reg <= port_next;
        end
    end

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    upe_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .port_filter (port_reg),
        .push        (push),
        .rec         (wr_rec)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_rec  (wr_rec),
        .pop     (pop),
        .rd_rec  (rd_rec),
        .empty   (q_empty),
        .full    (q_full)
    );

    upe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_rec   (rd_rec),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== dv/upe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upe_checker
// Watches the byte, result and port channels of the udp payload extractor.
// Every accepted byte is run through a bit-true frame parser that yields the
// payload and status items the block owes. Each accepted result is matched
// field by field against the oldest owed item.
// ----------------------------------------------------------------------------
module upe_checker
    import upe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // payload_byte[7:0], verdict[10:8],
                                        // payload_length[26:11], zero
    input  wire logic        m_tlast,
    input  wire logic        m_tuser,   // is_status[0]
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,  // port_filter[15:0]
    output int               fail_count,
    output int               due_count
);

    typedef struct packed {
        logic        is_status;
        logic [7:0]  pay;
        logic        last;
        verdict_t    verdict;
        logic [15:0] plen;
    } upe_item_t;

    upe_item_t   due_items[$];

    logic [15:0] port_sel;
    logic [16:0] pos;
    logic [15:0] etype;
    logic        tag_seen;
    logic [5:0]  ip_hdr_len;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] ulen;

    task automatic clear_frame_state();
        pos        = '0;
        etype      = '0;
        tag_seen   = 1'b0;
        ip_hdr_len = '0;
        proto      = '0;
        dport      = '0;
        ulen       = '0;
    endtask

    // verdict after len bytes; before the end a short frame is not yet a failure
    function automatic verdict_t classify_frame(input int len, input bit at_end);
        int ip;
        ip = tag_seen ? 18 : 14;
        if (len < 14 || (tag_seen && len < 18))
            return at_end ? VERDICT_RUNT : VERDICT_OK;
        if (etype != ETH_TYPE_IPV4)
            return VERDICT_NOT_IPV4;
        if (len < ip + 20)
            return at_end ? VERDICT_TRUNC : VERDICT_OK;
        if (ip_hdr_len < IP_HDR_MIN)
            return VERDICT_BAD_IHL;
        if (len < ip + ip_hdr_len + 8)
            return at_end ? VERDICT_TRUNC : VERDICT_OK;
        if (proto != IP_PROTO_UDP)
            return VERDICT_NOT_UDP;
        if (port_sel != 16'd0 && dport != port_sel)
            return VERDICT_PORT_MISS;
        if (ulen <= 16'd8)
            return VERDICT_BAD_LEN;
        if (at_end && ip + ip_hdr_len + ulen > len)
            return VERDICT_TRUNC;
        return VERDICT_OK;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        logic [7:0] b;
        int         p;
        int         ip;
        int         udp;
        int         len;
        verdict_t   hdr_fail;
        verdict_t   v;
        upe_item_t  item;

        if (!aresetn) begin
            clear_frame_state();
            port_sel   = '0;
            fail_count = 0;
            due_items.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                port_sel = cfg_data;

            if (s_tvalid && s_tready) begin
                b = s_tdata;
                if (pos < MAX_FRAME_BYTES) begin
                    p   = int'(pos);
                    ip  = tag_seen ? 18 : 14;
                    udp = ip + ip_hdr_len;
                    if (p == 12 || p == 13 || (tag_seen && (p == 16 || p == 17)))
                        etype = {etype[7:0], b};
                    if (p == 13)
                        tag_seen = (etype == ETH_TYPE_VLAN || etype == ETH_TYPE_QINQ);
                    if (p == ip)
                        ip_hdr_len = {b[3:0] & IHL_MASK, 2'b00};
                    if (p == ip + 9)
                        proto = b;
                    if (p > ip) begin
                        if (p == udp + 2 || p == udp + 3)
                            dport = {dport[7:0], b};
                        if (p == udp + 4 || p == udp + 5)
                            ulen = {ulen[7:0], b};
                    end
                    pos      = pos + 17'd1;
                    len      = int'(pos);
                    ip       = tag_seen ? 18 : 14;
                    udp      = ip + ip_hdr_len;
                    hdr_fail = classify_frame(len, 1'b0);
                    if (hdr_fail == VERDICT_OK && len >= ip + 20 && len > udp + 8 &&
                        p < udp + ulen) begin
                        item = '{is_status: 1'b0, pay: b, last: 1'b0,
                                 verdict: VERDICT_OK, plen: 16'd0};
                        due_items = {due_items, item};
                    end
                end
                if (s_tlast) begin
                    v    = classify_frame(int'(pos), 1'b1);
                    item = '{is_status: 1'b1, pay: 8'd0, last: 1'b1, verdict: v,
                             plen: (v == VERDICT_OK) ? ulen - 16'd8 : 16'd0};
                    due_items = {due_items, item};
                    clear_frame_state();
                end
            end

            if (m_tvalid && m_tready) begin
                if (due_items.size() == 0) begin
                    $display("%0t: unexpected result item, actual tuser %0b tdata 0x%0h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    item = due_items.pop_front();
                    check_field("is_status", 32'(item.is_status), 32'(m_tuser));
                    check_field("payload_byte", 32'(item.pay), 32'(m_tdata[7:0]));
                    check_field("last_in_frame", 32'(item.last), 32'(m_tlast));
                    check_field("verdict", 32'(item.verdict), 32'(m_tdata[10:8]));
                    check_field("payload_length", 32'(item.plen), 32'(m_tdata[26:11]));
                    check_field("tdata pad", 32'd0, 32'(m_tdata[31:27]));
                end
            end
        end
        due_count = due_items.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level stimulus for the udp payload extractor: directed frames for
// every verdict and tagging and several header lengths, then random frames
// under three idle mixes and several port filters, with a long receiver
// stall in each random phase. Results are judged by upe_checker.
// ----------------------------------------------------------------------------
module tb;
    import upe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef enum int {
        TAG_NONE,
        TAG_VLAN,
        TAG_QINQ
    } tag_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          due_count;
    int          cycles;
    int          send_idle;
    int          recv_idle;
    int          hold_request;
    int          hold_left;
    int          bytes_sent;
    logic [7:0]  frame_q[$];

    udp_payload_extractor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    upe_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("udp_payload_extractor test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = 400;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic int full_len(input tag_kind_t tk, input logic [3:0] ihl,
                                    input logic [15:0] ul);
        return ((tk == TAG_NONE) ? 14 : 18) + ihl * 4 + ul;
    endfunction

    function automatic void set_frame_byte(input int idx, input logic [7:0] v);
        if (idx >= 0 && idx < frame_q.size())
            frame_q[idx] = v;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic emit_frame(input tag_kind_t tk, input logic [15:0] et,
                              input logic [3:0] ihl, input logic [7:0] pr,
                              input logic [15:0] dp, input logic [15:0] ul,
                              input int total);
        int          ip;
        int          udp;
        logic [15:0] tag_type;
        ip  = (tk == TAG_NONE) ? 14 : 18;
        udp = ip + ihl * 4;
        if (total < 1)
            total = 1;
        frame_q.delete();
        for (int i = 0; i < total; i++)
            frame_q = {frame_q, 8'($urandom)};
        if (tk != TAG_NONE) begin
            tag_type = (tk == TAG_VLAN) ? ETH_TYPE_VLAN : ETH_TYPE_QINQ;
            set_frame_byte(12, tag_type[15:8]);
            set_frame_byte(13, tag_type[7:0]);
        end
        set_frame_byte(ip - 2, et[15:8]);
        set_frame_byte(ip - 1, et[7:0]);
        set_frame_byte(ip, {4'h4, ihl});
        set_frame_byte(ip + 9, pr);
        set_frame_byte(udp + 2, dp[15:8]);
        set_frame_byte(udp + 3, dp[7:0]);
        set_frame_byte(udp + 4, ul[15:8]);
        set_frame_byte(udp + 5, ul[7:0]);
        for (int i = 0; i < total; i++)
            send_byte(frame_q[i], i == total - 1);
        bytes_sent += total;
    endtask

    task automatic write_port(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (due_count != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_random_phase(input int budget, input logic [15:0] filt);
        int          start;
        int          r;
        int          full;
        int          total;
        bit          stalled;
        tag_kind_t   tk;
        logic [15:0] et;
        logic [15:0] dp;
        logic [15:0] ul;
        logic [3:0]  ihl;
        logic [7:0]  pr;
        start   = bytes_sent;
        stalled = 1'b0;
        while (bytes_sent - start < budget) begin
            if (!stalled && bytes_sent - start > budget / 3) begin
                hold_request = 1;
                stalled      = 1'b1;
            end
            r   = $urandom_range(99);
            tk  = tag_kind_t'($urandom_range(2));
            et  = ETH_TYPE_IPV4;
            ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
            pr  = IP_PROTO_UDP;
            dp  = (filt != 16'd0 && $urandom_range(4) != 0) ? filt : 16'($urandom);
            ul  = ($urandom_range(9) == 0) ? 16'($urandom_range(8))
                                           : 16'($urandom_range(18, 9));
            if (r >= 70 && r < 88) begin
                case ($urandom_range(3))
                    0: et = 16'($urandom);
                    1: ihl = 4'($urandom_range(4));
                    2: pr = 8'($urandom);
                    default: et = ETH_TYPE_VLAN;
                endcase
            end
            full = full_len(tk, ihl, ul);
            if (r >= 88)
                total = $urandom_range(40, 1);
            else if ($urandom_range(7) == 0)
                total = $urandom_range(full - 1, 1);
            else
                total = full + $urandom_range(6);
            emit_frame(tk, et, ihl, pr, dp, ul, total);
        end
    endtask

    initial begin
        logic [15:0] port_c;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        cycles       = 0;
        send_idle    = 0;
        recv_idle    = 0;
        hold_request = 0;
        hold_left    = 0;
        bytes_sent   = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames under a fixed port
        send_idle = 26;
        recv_idle = 51;
        write_port(16'h1234);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9, 1);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9, 13);
        emit_frame(TAG_VLAN, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9, 17);
        emit_frame(TAG_NONE, 16'h86DD, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9, 30);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9, 30);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9, 40);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd4, IP_PROTO_UDP, 16'h1234, 16'd12, 60);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd0, IP_PROTO_UDP, 16'h1234, 16'd12, 60);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, 8'd6, 16'h1234, 16'd12,
                   full_len(TAG_NONE, 4'd5, 16'd12));
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1235, 16'd12,
                   full_len(TAG_NONE, 4'd5, 16'd12));
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'hFFFF, 16'd12,
                   full_len(TAG_NONE, 4'd5, 16'd12));
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd8, 46);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd0, 50);
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd9,
                   full_len(TAG_NONE, 4'd5, 16'd9) + 6);
        emit_frame(TAG_VLAN, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd12,
                   full_len(TAG_VLAN, 4'd5, 16'd12));
        emit_frame(TAG_QINQ, ETH_TYPE_IPV4, 4'd15, IP_PROTO_UDP, 16'h1234, 16'd10,
                   full_len(TAG_QINQ, 4'd15, 16'd10));
        emit_frame(TAG_NONE, ETH_TYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'h1234, 16'd20,
                   full_len(TAG_NONE, 4'd5, 16'd20) - 3);
        wait_drained();

        write_port(16'h0000);
        run_random_phase(200, 16'h0000);
        wait_drained();

        send_idle = 51;
        recv_idle = 26;
        write_port(16'hFFFF);
        run_random_phase(200, 16'hFFFF);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        port_c    = 16'($urandom);
        write_port(port_c);
        run_random_phase(200, port_c);
        wait_drained();

        repeat (12) @(negedge aclk);
        if (fail_count == 0 && due_count == 0) begin
            $display("udp_payload_extractor test passed");
        end else begin
            $display("udp_payload_extractor test failed");
        end
        $finish;
    end

endmodule
